@@ rtl/smallest_prime_power_split_macros.svh @@
// Assertion macros for the prime power split block
`ifndef SMALLEST_PRIME_POWER_SPLIT_MACROS_SVH
`define SMALLEST_PRIME_POWER_SPLIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPPS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPPS_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPPS_ASSERT(label, clk, rst_n, prop, msg)
`define SPPS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/spps_pkg.sv @@
// ----------------------------------------------------------------------------
// spps_pkg
// Shared types for the prime power split block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package spps_pkg;
	// controller to datapath
	typedef struct packed {
		logic sieve_start;   // clear counters, begin sieve
		logic outer_step;    // read marks, push prime, restart k
		logic inner_step;    // write i*q, read next prime
		logic q_load;        // load query
		logic div_start;     // start one division
		logic mul_step;      // b *= p, a = quotient
		logic res_load;      // capture result
	} spps_cmd_t;
	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic outer_done;
		logic inner_done;
		logic div_busy;
		logic div_zero_rem;
		logic q_trivial;
	} spps_sts_t;
endpackage
`default_nettype wire

@@ rtl/smallest_prime_power_split.sv @@
// ----------------------------------------------------------------------------
// smallest_prime_power_split
// Splits a word into the full power of its smallest prime and the cofactor.
// ----------------------------------------------------------------------------
// After reset the block clears its tables, then builds a smallest-prime-factor
// table with a linear sieve; s_tready stays low until that is done. Each word
// then goes through the bit-serial divider, which divides out one factor of
// the smallest prime a pass until a nonzero remainder shows; values below two
// or beyond the table skip the divider. A new word is taken while the previous
// result waits on m_tready; the finished word then waits until that result
// has left.
// A result of found = 0 with zero values means the input was a prime power,
// below two, or beyond the table.
`timescale 1ns / 1ps
`default_nettype none
module smallest_prime_power_split import spps_pkg::*; #(
	parameter int MAX_VALUE = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // value[15:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // found, cofactor[16:1], prime_power[32:17], zero pad
);
	spps_cmd_t cmd;
	spps_sts_t sts;
	logic        found;
	logic [15:0] cof, pw;

	spps_ctrl u_ctrl (
		.clk, .arst_n, .cmd, .sts, .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready));
	spps_datapath #(.MaxValue(MAX_VALUE)) u_dp (
		.clk, .arst_n, .cmd, .sts, .value(s_tdata),
		.res_found(found), .res_cofactor(cof), .res_power(pw));

	assign m_tdata = {7'd0, pw, cof, found};
endmodule
`default_nettype wire

@@ rtl/spps_ram.sv @@
// ----------------------------------------------------------------------------
// spps_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spps_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/spps_div.sv @@
// ----------------------------------------------------------------------------
// spps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spps_div import spps_pkg::*; #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic      [W-1:0] quotient,
	output logic      [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [W:0]    trial;
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

@@ rtl/spps_datapath.sv @@
// ----------------------------------------------------------------------------
// spps_datapath
// Sieve tables, prime list, query divide loop and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "smallest_prime_power_split_macros.svh"
module spps_datapath import spps_pkg::*; #(
	parameter int MaxValue = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spps_cmd_t         cmd,
	output spps_sts_t              sts,
	input  wire logic [15:0]       value,
	output logic                   res_found,
	output logic [15:0]            res_cofactor,
	output logic [15:0]            res_power
);
	localparam int AW = $clog2(MaxValue);
	localparam int VW = AW + 1;
	localparam int PW = (AW > 16) ? AW : 16;
	localparam int PD = MaxValue / 2 + 2;
	localparam int PA = $clog2(PD);

	// Phases of sieve (driven by controller strobes):
	// clear: marks[n] <= 0 means "prime/unvisited" (inverted sense), walk all.
	logic [VW-1:0] clr_q;
	logic          clearing_q;
	logic [VW-1:0] i_q;
	logic [PA:0]   pc_q, k_q;
	logic [PW-1:0] q_rd, fac_rd;
	logic          mark_rd;

	// mark RAM: 1 = composite seen
	logic            mk_we;
	logic [AW-1:0]   mk_wa, mk_ra;
	logic            mk_wd;
	logic            fc_we;
	logic [AW-1:0]   fc_wa, fc_ra;
	logic [PW-1:0]   fc_wd;
	logic            pl_we;
	logic [PA-1:0]   pl_wa, pl_ra;

	// query regs
	logic [15:0] x_q, a_q, b_q, p_q;
	logic        range_ok_q;
	logic [15:0] dq, dr;
	logic        first_div;
	logic [15:0] div_a, div_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b0;
			clr_q      <= '0;
		end else if (cmd.sieve_start) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == VW'(MaxValue - 1)) clearing_q <= 1'b0;
		end
	end
	assign sts.clear_done = !clearing_q;

	// outer: i from 2; when marks read shows not composite, push prime.
	// mark_rd for i is read in the cycle before outer_step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q  <= '0;
			pc_q <= '0;
			k_q  <= '0;
		end else if (cmd.sieve_start) begin
			i_q  <= VW'(2);
			pc_q <= '0;
			k_q  <= '0;
		end else if (cmd.outer_step) begin
			if (!mark_rd && pc_q < (PA+1)'(PD)) pc_q <= pc_q + 1'b1;
			k_q <= '0;
		end else if (cmd.inner_step) begin
			k_q <= k_q + 1'b1;
			if (sts.inner_done) i_q <= i_q + 1'b1;
		end
	end
	// product of i and current prime q_rd
	logic [2*VW-1:0] prod;
	assign prod = (2*VW)'(i_q) * (2*VW)'(q_rd);
	logic over, k_end;
	assign over    = prod >= (2*VW)'(MaxValue);
	// inner loop: entry k uses q_rd, fac_rd is spf(i); i%q==0 iff q == spf(i)
	logic lastq;
	assign lastq = (q_rd == fac_rd);
	assign k_end = (k_q >= pc_q);
	assign sts.inner_done = k_end || over || lastq;
	assign sts.outer_done = (i_q >= VW'(MaxValue));

	assign mk_we = clearing_q || (cmd.inner_step && !k_end && !over);
	assign mk_wa = clearing_q ? clr_q[AW-1:0] : prod[AW-1:0];
	assign mk_wd = !clearing_q;
	assign mk_ra = i_q[AW-1:0];
	assign fc_we = clearing_q || (cmd.outer_step && !mark_rd)
		|| (cmd.inner_step && !k_end && !over);
	assign fc_wa = clearing_q ? clr_q[AW-1:0]
		: cmd.outer_step ? i_q[AW-1:0] : prod[AW-1:0];
	assign fc_wd = clearing_q ? '0 : cmd.outer_step ? PW'(i_q) : q_rd;
	// after the sieve the factor read stays on the held query value
	assign fc_ra = cmd.q_load ? AW'(value)
		: sts.outer_done ? AW'(x_q) : i_q[AW-1:0];
	assign pl_we = cmd.outer_step && !mark_rd && pc_q < (PA+1)'(PD);
	assign pl_wa = pc_q[PA-1:0];
	assign pl_ra = k_q[PA-1:0];

	spps_ram #(.Width(1), .Depth(MaxValue)) u_marks (
		.clk, .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mark_rd));
	spps_ram #(.Width(PW), .Depth(MaxValue)) u_factor (
		.clk, .we(fc_we), .waddr(fc_wa), .wdata(fc_wd), .raddr(fc_ra), .rdata(fac_rd));
	spps_ram #(.Width(PW), .Depth(PD)) u_primes (
		.clk, .we(pl_we), .waddr(pl_wa), .wdata(PW'(i_q)), .raddr(pl_ra), .rdata(q_rd));

	// query: first pass divides x by spf(x) straight from the table
	assign first_div = (b_q == 16'd0);
	assign div_a = first_div ? x_q : a_q;
	assign div_p = first_div ? fac_rd[15:0] : p_q;

	spps_div #(.W(16)) u_div (
		.clk, .arst_n, .start(cmd.div_start), .dividend(div_a), .divisor(div_p),
		.busy(sts.div_busy), .quotient(dq), .remainder(dr));
	assign sts.div_zero_rem = (dr == '0);
	assign sts.q_trivial = !range_ok_q || fac_rd < PW'(2);

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			x_q        <= value;
			range_ok_q <= (value >= 16'd2) && (32'(value) < 32'(MaxValue));
		end
		if (cmd.div_start && first_div) begin
			a_q <= x_q;
			b_q <= 16'd1;
			p_q <= fac_rd[15:0];
		end
		if (cmd.mul_step) begin
			a_q <= dq;
			b_q <= 16'(32'(b_q) * 32'(p_q));
		end
		if (cmd.q_load) b_q <= 16'd0;
		if (cmd.res_load) begin
			if (sts.q_trivial || a_q == 16'd1) begin
				res_found <= 1'b0; res_cofactor <= '0; res_power <= '0;
			end else begin
				res_found <= 1'b1; res_cofactor <= a_q; res_power <= b_q;
			end
		end
	end

	`SPPS_ASSERT(a_clear_quiet, clk, arst_n, clearing_q |-> !cmd.q_load, "query during clear")
	`SPPS_ASSERT(a_pc_bound, clk, arst_n, pc_q <= (PA+1)'(PD), "prime count overflow")
	`SPPS_ASSERT(a_div_start, clk, arst_n, cmd.div_start |=> sts.div_busy, "divider idle")
endmodule
`default_nettype wire

@@ rtl/spps_ctrl.sv @@
// ----------------------------------------------------------------------------
// spps_ctrl
// Sequencer for the sieve build and the per-word divide loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "smallest_prime_power_split_macros.svh"
module spps_ctrl import spps_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	output spps_cmd_t      cmd,
	input  wire spps_sts_t sts,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready
);
	localparam logic [3:0] S_BOOT = 4'd0, S_CLR = 4'd1, S_ORD = 4'd2, S_OWT = 4'd3,
		S_OUT = 4'd4, S_INN = 4'd5, S_IDLE = 4'd6, S_QRD = 4'd7, S_DST = 4'd8,
		S_DWT = 4'd9, S_RES = 4'd10, S_INW = 4'd11;
	logic [3:0] st_q, st_d;
	logic       ov_q;

	always_comb begin
		cmd  = '0;
		st_d = st_q;
		unique case (st_q)
			S_BOOT: begin cmd.sieve_start = 1'b1; st_d = S_CLR; end
			S_CLR:  if (sts.clear_done) st_d = S_ORD;
			S_ORD:  st_d = sts.outer_done ? S_IDLE : S_OWT;
			S_OWT:  begin cmd.outer_step = 1'b1; st_d = S_INW; end
			S_INW:  st_d = S_INN;
			S_INN: begin
				cmd.inner_step = 1'b1;
				st_d = sts.inner_done ? S_ORD : S_INW;
			end
			S_IDLE: if (in_valid) begin cmd.q_load = 1'b1; st_d = S_QRD; end
			S_QRD:  st_d = S_OUT;
			S_OUT: begin
				if (sts.q_trivial) st_d = S_RES;
				else begin cmd.div_start = 1'b1; st_d = S_DWT; end
			end
			S_DST:  begin cmd.div_start = 1'b1; st_d = S_DWT; end
			S_DWT: if (!sts.div_busy) begin
				if (sts.div_zero_rem) begin cmd.mul_step = 1'b1; st_d = S_DST; end
				else st_d = S_RES;
			end
			S_RES:  if (!ov_q) begin cmd.res_load = 1'b1; st_d = S_IDLE; end
			default: st_d = S_BOOT;
		endcase
	end
	// result register holds the previous word, so a new word may start meanwhile
	assign in_ready = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_BOOT;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.res_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
	assign out_valid = ov_q;

	`SPPS_ASSERT(a_no_early, clk, arst_n, in_ready |-> sts.outer_done, "ready before table")
	`SPPS_ASSERT(a_hold, clk, arst_n, (ov_q && !out_ready) |=> ov_q, "result dropped")
	`SPPS_ASSERT(a_one_cmd, clk, arst_n, $countones(cmd) <= 1, "command clash")
endmodule
`default_nettype wire
